FILE: sv/rcb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcb_pkg: shared types and constants of the rectangle clipper
// Coordinate types, configuration register indexes, command codes and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rcb_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W       = 16;
  localparam int COORD_W      = 18;  // translated far edge needs two more bits
  localparam int COUNT_W      = 5;
  localparam int IDX_W        = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int RESULT_LIMIT = 16;

  typedef logic        [DATA_W-1:0]  data_t;
  typedef logic signed [DATA_W-1:0]  sdata_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic        [IDX_W-1:0]   idx_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t CFG_ORIGIN_X   = 2'd0;
  localparam cfg_idx_t CFG_ORIGIN_Y   = 2'd1;
  localparam cfg_idx_t CFG_CLIP_COUNT = 2'd2;

  // Input command codes
  localparam logic CMD_CLIP = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // One clip table entry
  typedef struct packed {
    sdata_t left;
    sdata_t top;
    sdata_t right;
    sdata_t bottom;
  } clip_entry_t;

  // Controller state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic start_rect;  // translate rectangle, read entry 0
    logic load_entry;  // write one clip table entry
    logic step;        // retire the current entry, read the next one
    logic push_last;   // send the held box marked as last
  } rcb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic limit_zero;  // effective clip count is zero
    logic hit;         // current intersection is non-empty
    logic at_last;     // current entry is the final one to scan
    logic hold_valid;  // a box waits in the hold register
    logic out_free;    // output register can take a box this cycle
  } rcb_sts_t;

endpackage
`default_nettype wire

FILE: sv/rcb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcb_ctrl: sequencer of the rectangle clipper
// Accepts commands in idle, walks the clip table one entry per cycle unless the
// output stalls, and flushes the held box with the last mark at scan end.
// ----------------------------------------------------------------------------
module rcb_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire                   cmd_i,
  input  wire rcb_pkg::rcb_sts_t sts_i,
  output rcb_pkg::rcb_cmd_t     cmd_o
);

  rcb_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      rcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == rcb_pkg::CMD_LOAD) begin
            cmd_o.load_entry = 1'b1;
          end else begin
            cmd_o.start_rect = 1'b1;
            if (!sts_i.limit_zero) begin
              state_d = rcb_pkg::ST_SCAN;
            end
          end
        end
      end
      rcb_pkg::ST_SCAN: begin
        // stall only when a new box must displace the held one and the
        // output register is still occupied
        if (!(sts_i.hit && sts_i.hold_valid && !sts_i.out_free)) begin
          cmd_o.step = 1'b1;
          if (sts_i.at_last) begin
            state_d = rcb_pkg::ST_FINISH;
          end
        end
      end
      rcb_pkg::ST_FINISH: begin
        if (!sts_i.hold_valid) begin
          state_d = rcb_pkg::ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.push_last = 1'b1;
          state_d         = rcb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rcb_pkg::ST_IDLE;
      end
    endcase
  end

  // Assertions
  a_last_step_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && sts_i.at_last) |=> (state_q == rcb_pkg::ST_FINISH))
    else $error("scan of the final entry did not lead to finish");

  a_empty_clip_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start_rect && sts_i.limit_zero) |=> (state_q == rcb_pkg::ST_IDLE))
    else $error("rectangle with no clip boxes left idle");

  a_flush_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push_last |=> (state_q == rcb_pkg::ST_IDLE))
    else $error("flush of the last box did not return to idle");

endmodule
`default_nettype wire

FILE: sv/rcb_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcb_datapath: translation, clip table and intersection unit
// Holds the configuration registers, the clip table memory, the translated
// rectangle, one held box and the output register.
// ----------------------------------------------------------------------------
module rcb_datapath #(
  parameter int MAX_CLIP_BOXES = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // configuration
  input  wire                     cfg_we_i,
  input  wire  [1:0]              cfg_index_i,
  input  wire  [15:0]             cfg_data_i,
  // input payload
  input  wire  signed [15:0]      rect_x_i,
  input  wire  signed [15:0]      rect_y_i,
  input  wire  [15:0]             rect_width_i,
  input  wire  [15:0]             rect_height_i,
  input  wire  [3:0]              entry_index_i,
  input  wire  signed [15:0]      entry_left_i,
  input  wire  signed [15:0]      entry_top_i,
  input  wire  signed [15:0]      entry_right_i,
  input  wire  signed [15:0]      entry_bottom_i,
  // output channel
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic signed [15:0]      out_left_o,
  output logic signed [15:0]      out_top_o,
  output logic signed [15:0]      out_right_o,
  output logic signed [15:0]      out_bottom_o,
  output logic                    is_last_o,
  // control
  input  wire rcb_pkg::rcb_cmd_t  cmd_i,
  output rcb_pkg::rcb_sts_t       sts_o
);

  localparam int AW  = (MAX_CLIP_BOXES > 1) ? $clog2(MAX_CLIP_BOXES) : 1;
  localparam int EFF = (MAX_CLIP_BOXES < rcb_pkg::RESULT_LIMIT) ?
                       MAX_CLIP_BOXES : rcb_pkg::RESULT_LIMIT;
  localparam rcb_pkg::count_t EFF_LIMIT = rcb_pkg::count_t'(EFF);

  // Configuration registers
  rcb_pkg::sdata_t origin_x_q, origin_y_q;
  rcb_pkg::count_t clip_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      clip_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcb_pkg::CFG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        rcb_pkg::CFG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        rcb_pkg::CFG_CLIP_COUNT: clip_count_q <= cfg_data_i[rcb_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective scan length: count capped by table size and result limit
  rcb_pkg::count_t eff_limit;
  assign eff_limit = (clip_count_q > EFF_LIMIT) ? EFF_LIMIT : clip_count_q;

  // Rectangle translation, near edges wrap to 16 bits
  rcb_pkg::sdata_t tx16, ty16;
  rcb_pkg::coord_t tx, ty, tx2, ty2;
  assign tx16 = rect_x_i + origin_x_q;
  assign ty16 = rect_y_i + origin_y_q;
  assign tx   = {{2{tx16[15]}}, tx16};
  assign ty   = {{2{ty16[15]}}, ty16};
  assign tx2  = tx + {2'b00, rect_width_i};
  assign ty2  = ty + {2'b00, rect_height_i};

  rcb_pkg::coord_t x_q, y_q, x2_q, y2_q;
  rcb_pkg::count_t limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_rect) begin
      x_q     <= tx;
      y_q     <= ty;
      x2_q    <= tx2;
      y2_q    <= ty2;
      limit_q <= eff_limit;
    end
  end

  // Scan index
  rcb_pkg::idx_t idx_q, idx_d;
  logic          at_last;

  assign at_last = ({1'b0, idx_q} == (limit_q - rcb_pkg::count_t'(1)));
  assign idx_d   = idx_q + rcb_pkg::idx_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.start_rect) begin
      idx_q <= '0;
    end else if (cmd_i.step && !at_last) begin
      idx_q <= idx_d;
    end
  end

  // Clip table: one write port, one registered read port
  rcb_pkg::clip_entry_t mem [MAX_CLIP_BOXES];
  rcb_pkg::clip_entry_t rd_q;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  rcb_pkg::clip_entry_t wr_data;

  assign rd_en   = cmd_i.start_rect || (cmd_i.step && !at_last);
  assign rd_addr = cmd_i.start_rect ? '0 : AW'(idx_d);
  assign wr_en   = cmd_i.load_entry && (32'(entry_index_i) < MAX_CLIP_BOXES);
  assign wr_data = '{left: entry_left_i, top: entry_top_i,
                     right: entry_right_i, bottom: entry_bottom_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(entry_index_i)] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Intersection with the current entry
  rcb_pkg::coord_t bl, bt, br, bb;
  rcb_pkg::coord_t il, it, ir, ib;
  logic            hit;

  assign bl  = {{2{rd_q.left[15]}},   rd_q.left};
  assign bt  = {{2{rd_q.top[15]}},    rd_q.top};
  assign br  = {{2{rd_q.right[15]}},  rd_q.right};
  assign bb  = {{2{rd_q.bottom[15]}}, rd_q.bottom};
  assign il  = (x_q > bl)  ? x_q  : bl;
  assign it  = (y_q > bt)  ? y_q  : bt;
  assign ir  = (x2_q < br) ? x2_q : br;
  assign ib  = (y2_q < bb) ? y2_q : bb;
  assign hit = (il < ir) && (it < ib);

  // Held box: sent once the next box or the end of the scan is known
  rcb_pkg::clip_entry_t hold_q;
  logic                 hold_valid_q;
  logic                 capture, push;

  assign capture = cmd_i.step && hit;
  assign push    = (capture && hold_valid_q) || cmd_i.push_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (capture) begin
      hold_valid_q <= 1'b1;
    end else if (cmd_i.push_last) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      hold_q <= '{left: il[15:0], top: it[15:0], right: ir[15:0], bottom: ib[15:0]};
    end
  end

  // Output register
  logic out_valid_q;
  rcb_pkg::clip_entry_t out_q;
  logic                 out_last_q;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q      <= hold_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_left_o   = out_q.left;
  assign out_top_o    = out_q.top;
  assign out_right_o  = out_q.right;
  assign out_bottom_o = out_q.bottom;
  assign is_last_o    = out_last_q;

  // Status
  assign sts_o = '{limit_zero: (eff_limit == '0), hit: hit, at_last: at_last,
                   hold_valid: hold_valid_q, out_free: out_free};

  // Assertions
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!out_valid_q || out_ready_i))
    else $error("box sent while the output register was occupied");

  a_flush_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_last |-> hold_valid_q)
    else $error("last-box flush with an empty hold register");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !at_last && !cmd_i.start_rect) |=>
      (idx_q == rcb_pkg::idx_t'($past(idx_q) + rcb_pkg::idx_t'(1))))
    else $error("scan index did not advance after a step");

endmodule
`default_nettype wire

FILE: sv/rect_clip_to_box_list.sv
`default_nettype none
// Clip command: accepted in idle, then one clip table entry per cycle through
// the single intersection unit unless the output stalls, then a flush state;
// clip_count is capped by the table size and at 16, and when it is zero the
// scan is skipped. Load command: accepted in idle. A result goes to the output
// register when a later hit displaces the held box, or at the flush.
// Reset clears control and configuration registers; the clip table is undefined.
// ----------------------------------------------------------------------------
// rect_clip_to_box_list: clip rectangles against a stored clip box list
// Translates each rectangle by the drawable origin, intersects it with the
// first clip_count stored boxes (capped) and sends each non-empty intersection.
// ----------------------------------------------------------------------------
module rect_clip_to_box_list #(
  parameter int MAX_CLIP_BOXES = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // configuration port
  input  wire                cfg_we_i,
  input  wire  [1:0]         cfg_index_i,
  input  wire  [15:0]        cfg_data_i,
  // input channel
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire                cmd_i,
  input  wire  signed [15:0] rect_x_i,
  input  wire  signed [15:0] rect_y_i,
  input  wire  [15:0]        rect_width_i,
  input  wire  [15:0]        rect_height_i,
  input  wire  [3:0]         entry_index_i,
  input  wire  signed [15:0] entry_left_i,
  input  wire  signed [15:0] entry_top_i,
  input  wire  signed [15:0] entry_right_i,
  input  wire  signed [15:0] entry_bottom_i,
  // output channel
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [15:0] out_left_o,
  output logic signed [15:0] out_top_o,
  output logic signed [15:0] out_right_o,
  output logic signed [15:0] out_bottom_o,
  output logic               is_last_o
);

  rcb_pkg::rcb_cmd_t ctrl_cmd;
  rcb_pkg::rcb_sts_t dp_sts;

  // Sequencer
  rcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath
  rcb_datapath #(
    .MAX_CLIP_BOXES (MAX_CLIP_BOXES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .entry_index_i  (entry_index_i),
    .entry_left_i   (entry_left_i),
    .entry_top_i    (entry_top_i),
    .entry_right_i  (entry_right_i),
    .entry_bottom_i (entry_bottom_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_top_o      (out_top_o),
    .out_right_o    (out_right_o),
    .out_bottom_o   (out_bottom_o),
    .is_last_o      (is_last_o),
    .cmd_i          (ctrl_cmd),
    .sts_o          (dp_sts)
  );

endmodule
`default_nettype wire
